@@ src/lrs_pkg.sv @@
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int KIND_W   = 2;
    localparam int ROWSEL_W = 3;
    localparam int BYTE_W   = 8;
    localparam int HOLD_W   = 16;
    localparam int BITPOS_W = 5;
    localparam int WORD_W   = 32;
    localparam int DRIVE_W  = 8;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROW    = 2'd0,
        KIND_LIGHTS = 2'd1,
        KIND_TICK   = 2'd2
    } t_kind;

    typedef enum logic {
        PH_SHIFT = 1'b0,
        PH_HOLD  = 1'b1
    } t_phase;

    typedef struct packed {
        logic                serial_clock;
        logic                serial_data;
        logic [DRIVE_W-1:0]  row_drive_n;
        logic                shifting;
    } t_lines;

    typedef struct packed {
        logic                row_en;
        logic                lights_en;
        logic [ROWSEL_W-1:0] row;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic [BYTE_W-1:0]   lights;
    } t_frame_wr;

endpackage

@@ src/lrs_if.sv @@
`timescale 1ns / 1ps

interface lrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] row_index;
    logic [7:0] red_bits;
    logic [7:0] green_bits;
    logic [7:0] blue_bits;
    logic [7:0] lights_bits;

    modport source (output valid, kind, row_index, red_bits, green_bits, blue_bits,
                    lights_bits, input ready);
    modport sink   (input valid, kind, row_index, red_bits, green_bits, blue_bits,
                    lights_bits, output ready);
endinterface

interface lrs_out_if;
    logic       valid;
    logic       ready;
    logic       serial_clock;
    logic       serial_data;
    logic [7:0] row_drive_n;
    logic       shifting;

    modport source (output valid, serial_clock, serial_data, row_drive_n, shifting,
                    input ready);
    modport sink   (input valid, serial_clock, serial_data, row_drive_n, shifting,
                    output ready);
endinterface

@@ src/lrs_frame.sv @@
`timescale 1ns / 1ps

module lrs_frame import lrs_pkg::*; #(
    parameter int ROW_COUNT = 8,
    parameter int ROW_W     = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame_wr         i_wr,
    input  logic [ROW_W-1:0]  i_rd_row,
    output logic [WORD_W-1:0] o_word
);

    logic [BYTE_W-1:0] r_red    [ROW_COUNT];
    logic [BYTE_W-1:0] r_green  [ROW_COUNT];
    logic [BYTE_W-1:0] r_blue   [ROW_COUNT];
    logic [BYTE_W-1:0] r_lights;

    logic [31:0]      w_wr_wide;
    logic [ROW_W-1:0] w_wr_addr;
    logic             w_in_range;

    assign w_wr_wide  = 32'(i_wr.row);
    assign w_wr_addr  = w_wr_wide[ROW_W-1:0];
    assign w_in_range = w_wr_wide < 32'(ROW_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_red[i]   <= '0;
                r_green[i] <= '0;
                r_blue[i]  <= '0;
            end
            r_lights <= '0;
        end else begin
            if (i_wr.row_en && w_in_range) begin
                r_red[w_wr_addr]   <= i_wr.red;
                r_green[w_wr_addr] <= i_wr.green;
                r_blue[w_wr_addr]  <= i_wr.blue;
            end
            if (i_wr.lights_en) begin
                r_lights <= i_wr.lights;
            end
        end
    end

    assign o_word = {r_lights, r_red[i_rd_row], r_green[i_rd_row], r_blue[i_rd_row]};

endmodule

@@ src/led_matrix_row_scanner_unit.sv @@
`timescale 1ns / 1ps
// the result of an item is registered and valid in the cycle after the item is accepted
// throughput: one item per cycle, taken while the result register is empty or drained
// the rate is set by the result register; the scan state registers update once per accepted tick item
// reset (synchronous, active low) clears the frame store and scan state,
// sets hold_ticks to 1000 and the idle levels to clock 0, data 0, rows off

module led_matrix_row_scanner_unit import lrs_pkg::*; #(
    parameter int ROW_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold_ticks_we,
    input  logic [HOLD_W-1:0] i_hold_ticks_data,
    lrs_in_if.sink            i_item,
    lrs_out_if.source         o_result
);

    localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    logic [HOLD_W-1:0]   r_hold_ticks;
    t_phase              r_phase,  n_phase;
    logic [ROW_W-1:0]    r_row,    n_row;
    logic [BITPOS_W-1:0] r_bit,    n_bit;
    logic                r_half,   n_half;
    logic [HOLD_W-1:0]   r_hold,   n_hold;
    logic [WORD_W-1:0]   r_word,   n_word;
    t_lines              r_lines,  n_lines;
    logic                r_out_valid;
    t_lines              r_out;

    logic                w_accept;
    logic                w_tick;
    t_frame_wr           w_wr;
    logic [WORD_W-1:0]   w_frame_word;
    logic [WORD_W-1:0]   w_word;
    logic                w_first;
    logic [HOLD_W-1:0]   w_limit;
    logic                w_hold_done;
    logic [ROW_W:0]      w_row_inc;
    logic [ROW_W-1:0]    w_row_next;
    logic [DRIVE_W-1:0]  w_mask;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_tick       = w_accept && (i_item.kind == KIND_TICK);

    always_comb begin
        w_wr           = '0;
        w_wr.row_en    = w_accept && (i_item.kind == KIND_ROW);
        w_wr.lights_en = w_accept && (i_item.kind == KIND_LIGHTS);
        w_wr.row       = i_item.row_index;
        w_wr.red       = i_item.red_bits;
        w_wr.green     = i_item.green_bits;
        w_wr.blue      = i_item.blue_bits;
        w_wr.lights    = i_item.lights_bits;
    end

    lrs_frame #(
        .ROW_COUNT (ROW_COUNT),
        .ROW_W     (ROW_W)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_rd_row (r_row),
        .o_word   (w_frame_word)
    );

    assign w_first     = (r_bit == '0) && !r_half;
    assign w_word      = w_first ? w_frame_word : r_word;
    assign w_limit     = (r_hold_ticks == '0) ? HOLD_W'(1) : r_hold_ticks;
    assign w_hold_done = ({1'b0, r_hold} + (HOLD_W+1)'(1)) >= {1'b0, w_limit};
    assign w_row_inc   = {1'b0, r_row} + (ROW_W+1)'(1);
    assign w_row_next  = (32'(w_row_inc) == 32'(ROW_COUNT)) ? '0 : w_row_inc[ROW_W-1:0];

    always_comb begin
        w_mask = '1;
        if (32'(r_row) < 32'(DRIVE_W)) begin
            w_mask = ~(DRIVE_W'(1) << r_row);
        end
    end

    // scan state
    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_bit   = r_bit;
        n_half  = r_half;
        n_hold  = r_hold;
        n_word  = r_word;
        if (w_tick) begin
            case (r_phase)
                PH_SHIFT: begin
                    n_word = w_word;
                    if (!r_half) begin
                        n_half = 1'b1;
                    end else begin
                        n_half = 1'b0;
                        if (r_bit == '1) begin
                            n_bit   = '0;
                            n_phase = PH_HOLD;
                            n_hold  = '0;
                        end else begin
                            n_bit = r_bit + BITPOS_W'(1);
                        end
                    end
                end
                PH_HOLD: begin
                    if (w_hold_done) begin
                        n_hold  = '0;
                        n_phase = PH_SHIFT;
                        n_bit   = '0;
                        n_half  = 1'b0;
                        n_row   = w_row_next;
                    end else begin
                        n_hold = r_hold + HOLD_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_SHIFT;
                end
            endcase
        end
    end

    // driven levels
    always_comb begin
        n_lines = r_lines;
        if (w_tick) begin
            case (r_phase)
                PH_SHIFT: begin
                    n_lines.serial_clock = r_half;
                    n_lines.serial_data  = w_word[~r_bit];
                    n_lines.row_drive_n  = '1;
                    n_lines.shifting     = 1'b1;
                end
                PH_HOLD: begin
                    n_lines.serial_clock = 1'b0;
                    n_lines.serial_data  = 1'b0;
                    n_lines.row_drive_n  = w_mask;
                    n_lines.shifting     = 1'b0;
                end
                default: begin
                    n_lines = r_lines;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks        <= HOLD_RESET;
            r_phase             <= PH_SHIFT;
            r_row               <= '0;
            r_bit               <= '0;
            r_half              <= 1'b0;
            r_hold              <= '0;
            r_word              <= '0;
            r_lines.serial_clock <= 1'b0;
            r_lines.serial_data  <= 1'b0;
            r_lines.row_drive_n  <= '1;
            r_lines.shifting     <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_hold_ticks_we) begin
                r_hold_ticks <= i_hold_ticks_data;
            end
            r_phase <= n_phase;
            r_row   <= n_row;
            r_bit   <= n_bit;
            r_half  <= n_half;
            r_hold  <= n_hold;
            r_word  <= n_word;
            r_lines <= n_lines;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_lines;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.serial_clock = r_out.serial_clock;
    assign o_result.serial_data  = r_out.serial_data;
    assign o_result.row_drive_n  = r_out.row_drive_n;
    assign o_result.shifting     = r_out.shifting;

endmodule
